@@ design/vsa_pkg.sv @@
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared fixed constants of the voice slot allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

  localparam int MaskBits   = 16;   // width of the mixer idle mask
  localparam int LevelBits  = 8;    // captured volume width
  localparam int LevelLimit = 256;  // start value of the quietest-voice search
  localparam int VoiceBits  = 4;    // width of the voice field
  localparam int SourceBits = 8;    // width of source fields on the ports
  localparam int FormatBits = 2;

  localparam logic ActPlay  = 1'b0;
  localparam logic ActPause = 1'b1;

endpackage

@@ design/voice_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// voice_slot_allocator
// Voice table with lowest-free allocation and quietest-voice stealing.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                payload
//  in       sink       in_valid_i / in_ready_o  action, source, volume, hold, format, idle
//  out      source     out_valid_o / out_ready_i voice, stopped, steal, evicted, format
//
//  Play: from accept to result, one RAM read per voice in the scan, then the
//  write-back of the chosen entry.
//  Pause: the held entry is read at accept, compared the cycle after.
//  Occupied marks are flops cleared by reset; the owner/volume RAM needs no
//  clearing pass. A stalled result holds the block in its final step; a new
//  word is taken while the previous result still waits on the output.
// ----------------------------------------------------------------------------
module voice_slot_allocator #(
  parameter int VOICE_COUNT = 16,
  parameter int SOURCE_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             action_i,
  input  logic [vsa_pkg::SourceBits-1:0]   source_id_i,
  input  logic [vsa_pkg::LevelBits-1:0]    source_volume_i,
  input  logic                             has_voice_i,
  input  logic [vsa_pkg::VoiceBits-1:0]    held_voice_i,
  input  logic                             is_mono_i,
  input  logic                             is_eight_bit_i,
  input  logic [vsa_pkg::MaskBits-1:0]     idle_voice_mask_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [vsa_pkg::VoiceBits-1:0]    voice_o,
  output logic                             voice_stopped_o,
  output logic                             stole_voice_o,
  output logic [vsa_pkg::SourceBits-1:0]   evicted_source_o,
  output logic [vsa_pkg::FormatBits-1:0]   format_code_o
);

  import vsa_pkg::*;

  localparam int IW = $clog2(VOICE_COUNT);
  localparam int EW = SOURCE_BITS + LevelBits;
  localparam int MW = LevelBits + 1;

  typedef enum logic [1:0] {
    StIdle,
    StPause,
    StScan,
    StFin
  } state_e;

  state_e state_q;

  // captured request
  logic                   act_q;
  logic [SOURCE_BITS-1:0] src_q;
  logic [LevelBits-1:0]   vol_q;
  logic                   has_q;
  logic [VoiceBits-1:0]   held_q;
  logic                   mono_q;
  logic                   eight_q;
  logic [MaskBits-1:0]    idle_q;

  // table and scan state
  logic [VOICE_COUNT-1:0] occ_q;
  logic [IW-1:0]          idx_q;
  logic                   found_q;
  logic [IW-1:0]          pick_q;
  logic [MW-1:0]          min_lvl_q;
  logic [IW-1:0]          min_idx_q;
  logic [SOURCE_BITS-1:0] min_own_q;
  logic                   out_valid_q;

  logic                   ram_we;
  logic [IW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_wdata;
  logic [EW-1:0]          ram_rdata;
  logic [SOURCE_BITS-1:0] rd_own;
  logic [LevelBits-1:0]   rd_lvl;

  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic          held_in_range;
  logic [IW-1:0] held_idx;
  logic          cur_occ;
  logic          cur_idle;
  logic          cur_free;
  logic          cur_lower;
  logic          last;
  logic [IW-1:0] chosen;
  logic          stop_hit;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = ((state_q == StPause) || (state_q == StFin)) && out_free;

  assign rd_own = ram_rdata[EW-1:LevelBits];
  assign rd_lvl = ram_rdata[LevelBits-1:0];

  assign held_in_range = (32'(held_q) < VOICE_COUNT);
  assign held_idx      = IW'(held_q);

  assign cur_occ   = occ_q[idx_q];
  assign cur_idle  = (32'(idx_q) < MaskBits) && idle_q[VoiceBits'(idx_q)];
  assign cur_free  = !cur_occ || cur_idle;
  assign cur_lower = cur_occ && ({1'b0, rd_lvl} < min_lvl_q);
  assign last      = (32'(idx_q) == VOICE_COUNT - 1);
  assign chosen    = found_q ? pick_q : min_idx_q;

  assign stop_hit = (act_q == ActPause) && has_q && held_in_range &&
                    occ_q[held_idx] && (rd_own == src_q);

  assign ram_we    = (state_q == StFin) && out_free;
  assign ram_wdata = {src_q, vol_q};

  always_comb begin
    case (state_q)
      StIdle:  ram_raddr = (action_i == ActPause) ? IW'(held_voice_i) : '0;
      StPause: ram_raddr = held_idx;
      StScan:  ram_raddr = IW'(idx_q + 1'b1);
      default: ram_raddr = '0;
    endcase
  end

  vsa_ram #(
    .WIDTH(EW),
    .DEPTH(VOICE_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(chosen),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q   <= action_i;
      src_q   <= SOURCE_BITS'(source_id_i);
      vol_q   <= source_volume_i;
      has_q   <= has_voice_i;
      held_q  <= held_voice_i;
      mono_q  <= is_mono_i;
      eight_q <= is_eight_bit_i;
      idle_q  <= idle_voice_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      occ_q            <= '0;
      idx_q            <= '0;
      found_q          <= 1'b0;
      pick_q           <= '0;
      min_lvl_q        <= MW'(LevelLimit);
      min_idx_q        <= '0;
      min_own_q        <= '0;
      out_valid_q      <= 1'b0;
      voice_o          <= '0;
      voice_stopped_o  <= 1'b0;
      stole_voice_o    <= 1'b0;
      evicted_source_o <= '0;
      format_code_o    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (action_i == ActPause) begin
              state_q <= StPause;
            end else begin
              state_q   <= StScan;
              idx_q     <= '0;
              found_q   <= 1'b0;
              min_lvl_q <= MW'(LevelLimit);
              min_idx_q <= '0;
            end
          end
        end
        StPause: begin
          if (out_free) begin
            voice_o          <= stop_hit ? held_q : '0;
            voice_stopped_o  <= stop_hit;
            stole_voice_o    <= 1'b0;
            evicted_source_o <= '0;
            format_code_o    <= '0;
            if (stop_hit) begin
              occ_q[held_idx] <= 1'b0;
            end
            state_q <= StIdle;
          end
        end
        StScan: begin
          if (!found_q && cur_free) begin
            found_q <= 1'b1;
            pick_q  <= idx_q;
          end
          if (cur_lower) begin
            min_lvl_q <= {1'b0, rd_lvl};
            min_idx_q <= idx_q;
            min_own_q <= rd_own;
          end
          if (last) begin
            state_q <= StFin;
          end else begin
            idx_q <= IW'(idx_q + 1'b1);
          end
        end
        StFin: begin
          if (out_free) begin
            occ_q[chosen]    <= 1'b1;
            voice_o          <= VoiceBits'(chosen);
            voice_stopped_o  <= 1'b0;
            stole_voice_o    <= !found_q;
            evicted_source_o <= found_q ? '0 : SourceBits'(min_own_q);
            format_code_o    <= {~mono_q, ~eight_q};
            state_q          <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // a steal only happens with every voice taken
  a_steal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) && !found_q |-> &occ_q)
    else $error("steal with a free voice");

  a_play_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> occ_q[$past(chosen)])
    else $error("assigned voice not marked occupied");

  a_pause_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPause) && out_free && stop_hit |=> !occ_q[$past(held_idx)])
    else $error("stopped voice still occupied");

  a_pause_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && voice_stopped_o |-> !stole_voice_o && (format_code_o == '0))
    else $error("pause result carries play fields");

endmodule

@@ design/vsa_ram.sv @@
// ----------------------------------------------------------------------------
// vsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ verif/tb_voice_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_voice_slot_allocator
// Self-checking bench for the voice slot allocator: a queue-fed driver offers
// play and pause words in random bursts, and a monitor predicts each result
// from its own copy of the voice table and checks every field in order.
// ----------------------------------------------------------------------------
module tb_voice_slot_allocator;
  import vsa_pkg::*;

  localparam int NumVoices  = 16;
  localparam int RandWords  = 1150;
  localparam int DrainAt    = 600;
  localparam int HoldStart  = 4000;
  localparam int HoldCycles = 600;
  localparam int IdleLimit  = 5000;
  localparam int TailCycles = 2 * NumVoices + 8;

  typedef struct packed {
    logic                  action;
    logic [SourceBits-1:0] src;
    logic [LevelBits-1:0]  vol;
    logic                  has;
    logic [VoiceBits-1:0]  held;
    logic                  mono;
    logic                  eight;
    logic [MaskBits-1:0]   idle;
  } voice_req_t;

  typedef struct packed {
    logic [VoiceBits-1:0]  voice;
    logic                  stopped;
    logic                  stole;
    logic [SourceBits-1:0] evicted;
    logic [FormatBits-1:0] fmt;
  } voice_res_t;

  typedef struct packed {
    logic [NumVoices-1:0]                 busy;
    logic [NumVoices-1:0][SourceBits-1:0] owner;
    logic [NumVoices-1:0][LevelBits-1:0]  level;
  } voice_tbl_t;

  typedef struct packed {
    voice_tbl_t tbl;
    voice_res_t res;
  } alloc_step_t;

  typedef enum logic [1:0] {RdyOpen, RdyRandom, RdyChoked} rdy_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  action_i = ActPlay;
  logic [SourceBits-1:0] source_id_i = '0;
  logic [LevelBits-1:0]  source_volume_i = '0;
  logic                  has_voice_i = 1'b0;
  logic [VoiceBits-1:0]  held_voice_i = '0;
  logic                  is_mono_i = 1'b0;
  logic                  is_eight_bit_i = 1'b0;
  logic [MaskBits-1:0]   idle_voice_mask_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [VoiceBits-1:0]  voice_o;
  logic                  voice_stopped_o;
  logic                  stole_voice_o;
  logic [SourceBits-1:0] evicted_source_o;
  logic [FormatBits-1:0] format_code_o;

  voice_req_t pending_words[$];
  voice_res_t want_results[$];
  voice_tbl_t gen_tbl = '0;
  voice_tbl_t chk_tbl = '0;

  int n_sent = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  int mode_left = 0;
  rdy_mode_e rdy_mode = RdyOpen;

  voice_slot_allocator #(
    .VOICE_COUNT(NumVoices),
    .SOURCE_BITS(SourceBits)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .source_id_i      (source_id_i),
    .source_volume_i  (source_volume_i),
    .has_voice_i      (has_voice_i),
    .held_voice_i     (held_voice_i),
    .is_mono_i        (is_mono_i),
    .is_eight_bit_i   (is_eight_bit_i),
    .idle_voice_mask_i(idle_voice_mask_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .voice_o          (voice_o),
    .voice_stopped_o  (voice_stopped_o),
    .stole_voice_o    (stole_voice_o),
    .evicted_source_o (evicted_source_o),
    .format_code_o    (format_code_o)
  );

  always #5 clk_i = ~clk_i;

  // lowest free-or-idle voice, else the quietest busy voice (lowest index on ties)
  function automatic alloc_step_t alloc_step(voice_tbl_t t, voice_req_t r);
    alloc_step_t s;
    int pick;
    int lowest;
    int v;
    s = '0;
    s.tbl = t;
    pick = -1;
    if (r.action == ActPause) begin
      if (r.has && t.busy[r.held] && t.owner[r.held] == r.src) begin
        s.tbl.busy[r.held] = 1'b0;
        s.res.voice = r.held;
        s.res.stopped = 1'b1;
      end
    end else begin
      for (v = 0; v < NumVoices; v++) begin
        if (pick < 0 && (!t.busy[v] || (v < MaskBits && r.idle[v]))) begin
          pick = v;
        end
      end
      if (pick < 0) begin
        lowest = LevelLimit;
        pick = 0;
        for (v = 0; v < NumVoices; v++) begin
          if (t.busy[v] && int'(t.level[v]) < lowest) begin
            lowest = t.level[v];
            pick = v;
          end
        end
        s.res.stole = 1'b1;
        s.res.evicted = t.owner[pick];
      end
      s.tbl.busy[pick] = 1'b1;
      s.tbl.owner[pick] = r.src;
      s.tbl.level[pick] = r.vol;
      s.res.voice = pick[VoiceBits-1:0];
      s.res.fmt = {~r.mono, ~r.eight};
    end
    return s;
  endfunction

  task automatic queue_word(voice_req_t r);
    alloc_step_t s;
    s = alloc_step(gen_tbl, r);
    gen_tbl = s.tbl;
    pending_words.push_back(r);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    if (mismatches < 50) begin
      $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $time);
    end
    mismatches++;
  endtask

  function automatic logic [MaskBits-1:0] rand_mask();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return '0;
    if (sel < 80) return MaskBits'(1) << $urandom_range(0, MaskBits - 1);
    if (sel < 95) return MaskBits'($urandom);
    return '1;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        void'(pending_words.pop_front());
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (n_sent == DrainAt &&
                     (want_results.size() != 0 || (in_valid_i && in_ready_o))) begin
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          action_i          <= pending_words[0].action;
          source_id_i       <= pending_words[0].src;
          source_volume_i   <= pending_words[0].vol;
          has_voice_i       <= pending_words[0].has;
          held_voice_i      <= pending_words[0].held;
          is_mono_i         <= pending_words[0].mono;
          is_eight_bit_i    <= pending_words[0].eight;
          idle_voice_mask_i <= pending_words[0].idle;
          in_valid_i        <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == HoldStart) begin
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rdy_mode = rdy_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (rdy_mode)
          RdyOpen:   out_ready_i <= 1'b1;
          RdyRandom: out_ready_i <= 1'($urandom_range(0, 1));
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    voice_req_t  r;
    alloc_step_t s;
    voice_res_t  w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        r = '{action_i, source_id_i, source_volume_i, has_voice_i, held_voice_i,
              is_mono_i, is_eight_bit_i, idle_voice_mask_i};
        s = alloc_step(chk_tbl, r);
        chk_tbl = s.tbl;
        want_results.push_back(s.res);
      end
      if (out_valid_o && out_ready_i) begin
        if (want_results.size() == 0) begin
          report_mismatch("unexpected word, voice", voice_o, -1);
        end else begin
          w = want_results.pop_front();
          if (voice_o !== w.voice) report_mismatch("voice", voice_o, w.voice);
          if (voice_stopped_o !== w.stopped)
            report_mismatch("voice_stopped", voice_stopped_o, w.stopped);
          if (stole_voice_o !== w.stole)
            report_mismatch("stole_voice", stole_voice_o, w.stole);
          if (evicted_source_o !== w.evicted)
            report_mismatch("evicted_source", evicted_source_o, w.evicted);
          if (format_code_o !== w.fmt)
            report_mismatch("format_code", format_code_o, w.fmt);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("timeout: no word moved for %0d cycles", IdleLimit);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    voice_req_t r;
    int v;
    int i;
    int n_busy;
    int sel;
    int busy_list[NumVoices];

    // pause on an empty table
    r = '0;
    r.action = ActPause;
    r.has = 1'b1;
    queue_word(r);
    // fill every voice; two quietest at voices 5 and 12 tie
    for (v = 0; v < NumVoices; v++) begin
      r = '0;
      r.action = ActPlay;
      r.src = SourceBits'(v * 17);
      r.vol = (v == 0) ? 8'd255 : ((v == 5 || v == 12) ? 8'd0 : LevelBits'(10 + v));
      r.mono = v[0];
      r.eight = v[1];
      queue_word(r);
    end
    // steals: tie goes to the lower voice, then the other
    r = '0;
    r.action = ActPlay;
    r.src = 8'hA5;
    r.vol = 8'd50;
    queue_word(r);
    r.src = 8'h5A;
    queue_word(r);
    // idle but occupied voices reused without a steal
    r.idle = 16'h8000;
    r.src = 8'h33;
    queue_word(r);
    r.idle = 16'hFFFF;
    r.src = 8'hFF;
    queue_word(r);
    // pause: wrong owner, no held voice, then good pauses at both ends
    r = '0;
    r.action = ActPause;
    r.has = 1'b1;
    r.held = 4'd3;
    r.src = gen_tbl.owner[3] + 8'd1;
    queue_word(r);
    r.has = 1'b0;
    r.src = gen_tbl.owner[3];
    queue_word(r);
    r.has = 1'b1;
    r.held = 4'd0;
    r.src = gen_tbl.owner[0];
    queue_word(r);
    r.held = 4'd15;
    r.src = gen_tbl.owner[15];
    queue_word(r);
    // holder of voice 1 plays again and gets a new voice
    r = '0;
    r.action = ActPlay;
    r.src = gen_tbl.owner[1];
    r.vol = 8'd1;
    queue_word(r);

    for (i = 0; i < RandWords; i++) begin
      sel = $urandom_range(0, 99);
      r.src = ($urandom_range(0, 3) == 0) ? SourceBits'($urandom)
                                          : SourceBits'($urandom_range(0, 11));
      r.vol = ($urandom_range(0, 1) == 0) ? LevelBits'($urandom)
                                          : LevelBits'($urandom_range(0, 3));
      r.has = 1'($urandom);
      r.held = VoiceBits'($urandom);
      r.mono = 1'($urandom);
      r.eight = 1'($urandom);
      r.idle = rand_mask();
      if (sel < 8) begin
        r.action = 1'($urandom);
        r.src = SourceBits'($urandom);
        r.vol = LevelBits'($urandom);
        r.idle = MaskBits'($urandom);
      end else if (sel < 60) begin
        r.action = ActPlay;
      end else begin
        r.action = ActPause;
        n_busy = 0;
        for (v = 0; v < NumVoices; v++) begin
          if (gen_tbl.busy[v]) begin
            busy_list[n_busy] = v;
            n_busy++;
          end
        end
        if (n_busy > 0 && $urandom_range(0, 99) < 85) begin
          r.held = VoiceBits'(busy_list[$urandom_range(0, n_busy - 1)]);
          r.src = gen_tbl.owner[r.held];
          r.has = ($urandom_range(0, 5) != 0);
        end
      end
      queue_word(r);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (want_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
